// File: design/slpr_pkg.sv
// Shared types and constants for the sync/length packet receiver.
package slpr_pkg;

  localparam int unsigned BufferDepth = 512;
  localparam int unsigned AddrW       = 9;
  localparam int unsigned TimerW      = 16;
  localparam int unsigned LenW        = 9;

  localparam logic [TimerW-1:0] TimeoutReset = TimerW'(50);

  localparam logic [7:0] SyncFirst  = 8'hFF;
  localparam logic [7:0] SyncSecond = 8'h00;

  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhSync2 = 2'd1,
    PhLen   = 2'd2,
    PhBody  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    StIdle    = 2'd0,
    StBusy    = 2'd1,
    StDone    = 2'd2,
    StTimeout = 2'd3
  } status_e;

  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic             write_enable;
    logic [AddrW-1:0] write_address;
    logic [7:0]       write_data;
    logic [LenW-1:0]  packet_length;
  } result_t;

  // Handshake between the pipeline stages.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

// File: design/slpr_in_reg.sv
// Input register stage: captures one item from the slave side.
module slpr_in_reg import slpr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_axis_tvalid_i,
  output logic  s_axis_tready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign valid_d         = s_axis_tready_o ? s_axis_tvalid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: design/slpr_core.sv
// Framing state machine, write pointer and timeout counter.
module slpr_core import slpr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TimerW-1:0] cfg_wdata_i,
  input  stage_ctl_t        ctl_i,
  input  item_t             item_i,
  output result_t           result_o
);

  phase_e            phase_q, phase_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [7:0]        len_q, len_d;
  logic [LenW-1:0]   bc_q, bc_d;
  logic [TimerW-1:0] ticks_q, ticks_d;
  logic [TimerW-1:0] timeout_q;

  logic             fire;
  logic             take;
  logic             done;
  logic             expired;
  logic [LenW-1:0]  bc_inc;
  logic [AddrW-1:0] ptr_inc;

  assign fire    = ctl_i.valid && ctl_i.advance;
  assign bc_inc  = bc_q + LenW'(1);
  assign ptr_inc = (ptr_q == AddrW'(BufferDepth - 1)) ? '0 : ptr_q + AddrW'(1);
  assign expired = (ticks_q == '0);

  // Shared decode of the current item
  always_comb begin
    take = 1'b0;
    done = 1'b0;
    if (item_i.opcode == OpByte) begin
      unique case (phase_q)
        PhHunt:  take = (item_i.data_byte == SyncFirst);
        PhSync2: take = (item_i.data_byte == SyncSecond);
        PhLen:   take = 1'b1;
        PhBody: begin
          take = 1'b1;
          done = ({1'b0, bc_inc} >= ({2'b00, len_q} + 10'd2));
        end
        default: take = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    ptr_d   = ptr_q;
    len_d   = len_q;
    bc_d    = bc_q;
    ticks_d = ticks_q;
    if (cfg_we_i) begin
      ticks_d = cfg_wdata_i;
    end else if (fire) begin
      if (take) begin
        ptr_d = ptr_inc;
      end
      if (item_i.opcode == OpByte) begin
        unique case (phase_q)
          PhHunt: begin
            if (take) phase_d = PhSync2;
          end
          PhSync2: begin
            if (take) begin
              phase_d = PhLen;
            end else begin
              phase_d = PhHunt;
              ptr_d   = '0;
            end
          end
          PhLen: begin
            len_d   = item_i.data_byte;
            bc_d    = '0;
            phase_d = PhBody;
          end
          PhBody: bc_d = bc_inc;
          default: phase_d = PhHunt;
        endcase
      end
      if (done || expired) begin
        phase_d = PhHunt;
        ptr_d   = '0;
        bc_d    = '0;
        ticks_d = timeout_q;
      end else begin
        ticks_d = ticks_q - TimerW'(1);
      end
    end
  end

  // Result of the current item
  always_comb begin
    result_o               = '0;
    result_o.write_enable  = take;
    if (take) begin
      result_o.status        = StBusy;
      result_o.write_address = ptr_q;
      result_o.write_data    = item_i.data_byte;
    end
    if (done) begin
      result_o.status        = StDone;
      result_o.packet_length = bc_inc + LenW'(2);
    end else if (expired) begin
      result_o.status = StTimeout;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      ptr_q     <= '0;
      len_q     <= '0;
      bc_q      <= '0;
      ticks_q   <= TimeoutReset;
      timeout_q <= TimeoutReset;
    end else begin
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      len_q   <= len_d;
      bc_q    <= bc_d;
      ticks_q <= ticks_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: design/slpr_out_reg.sv
// Result register stage towards the master side.
module slpr_out_reg import slpr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  output logic    advance_o,
  input  logic    m_axis_tready_i,
  output logic    m_axis_tvalid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // Stage may load when empty or when the held item leaves this cycle
  assign advance_o = !valid_q || m_axis_tready_i;
  assign valid_d   = advance_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign result_o        = result_q;

endmodule

// File: design/sync_length_packet_receiver.sv
// An accepted item passes through the input register, then the result
// register, before its result appears.
// Throughput: one item per cycle, one result per item; input keeps flowing
// while a result waits until both registers hold items.
// Reset (rst_ni, async, active low): hunting, pointer and counts zero,
// timeout 50; no clearing pass.
module sync_length_packet_receiver import slpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // timeout_ticks
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tuser_i,  // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [8:0] write_address, [16:9] write_data,
                                       // [25:17] packet_length, [31:26] zero
  output logic [2:0]  m_axis_tuser_o   // [1:0] status, [2] write_enable
);

  item_t      in_item, reg_item;
  logic       in_valid;
  logic       out_advance;
  stage_ctl_t ctl;
  result_t    core_res, out_res;

  assign in_item.opcode    = op_e'(s_axis_tuser_i);
  assign in_item.data_byte = s_axis_tdata_i;
  assign ctl.valid         = in_valid;
  assign ctl.advance       = out_advance;

  slpr_in_reg u_in_reg (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .item_i    (in_item),
    .advance_i (out_advance),
    .valid_o   (in_valid),
    .item_o    (reg_item)
  );

  slpr_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .ctl_i    (ctl),
    .item_i   (reg_item),
    .result_o (core_res)
  );

  slpr_out_reg u_out_reg (
    .clk_i,
    .rst_ni,
    .valid_i   (in_valid),
    .result_i  (core_res),
    .advance_o (out_advance),
    .m_axis_tready_i,
    .m_axis_tvalid_o,
    .result_o  (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.packet_length, out_res.write_data,
                           out_res.write_address};
  assign m_axis_tuser_o = {out_res.write_enable, out_res.status};

endmodule

// File: design/slpr_checker.sv
// Port-level checks on the packet receiver, bound to the top level.
module slpr_port_checker import slpr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // No write means no address or data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[2] |-> m_axis_tdata_o[16:0] == 17'd0)
    else $error("address or data without write");

  // A completion is always the final byte written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == StDone |-> m_axis_tuser_o[2])
    else $error("completion without write");

  // Length only reported on completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] != StDone |-> m_axis_tdata_o[25:17] == 9'd0)
    else $error("length outside completion");

  // Idle status never writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == StIdle |-> !m_axis_tuser_o[2])
    else $error("write while idle");

endmodule

bind sync_length_packet_receiver slpr_port_checker u_slpr_port_checker (
  .clk_i,
  .rst_ni,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tuser_o
);

// File: tb/sv/slpr_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the packet receiver, predicts every report and compares it.
module slpr_checker import slpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic [2:0]  m_axis_tuser_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  localparam logic [15:0] ResetTimeout = 16'd50;

  logic [15:0]      timeout_ticks;
  phase_e           phase;
  logic [AddrW-1:0] wr_ptr;
  logic [7:0]       decl_len;
  logic [8:0]       body_cnt;
  logic [16:0]      ticks_left;
  result_t          report_q[$];

  // back to hunting with a fresh allowance
  function automatic void rearm();
    phase      = PhHunt;
    wr_ptr     = '0;
    body_cnt   = '0;
    ticks_left = {1'b0, timeout_ticks};
  endfunction

  function automatic logic [AddrW-1:0] claim_slot();
    logic [AddrW-1:0] slot;
    slot = wr_ptr;
    if (int'(wr_ptr) + 1 >= BufferDepth) wr_ptr = '0;
    else wr_ptr = wr_ptr + 1'b1;
    return slot;
  endfunction

  function automatic result_t deframe_step(item_t it);
    result_t r;
    logic    done;
    r      = '0;
    done   = 1'b0;
    if (it.opcode == OpByte) begin
      case (phase)
        PhHunt: begin
          if (it.data_byte == SyncFirst) begin
            r.write_enable  = 1'b1;
            r.write_address = claim_slot();
            r.status        = StBusy;
            phase           = PhSync2;
          end
        end
        PhSync2: begin
          if (it.data_byte == SyncSecond) begin
            r.write_enable  = 1'b1;
            r.write_address = claim_slot();
            r.status        = StBusy;
            phase           = PhLen;
          end else begin
            // a stray 0xFF here does not restart the pair
            wr_ptr = '0;
            phase  = PhHunt;
          end
        end
        PhLen: begin
          r.write_enable  = 1'b1;
          r.write_address = claim_slot();
          r.status        = StBusy;
          decl_len        = it.data_byte;
          body_cnt        = '0;
          phase           = PhBody;
        end
        default: begin
          r.write_enable  = 1'b1;
          r.write_address = claim_slot();
          body_cnt        = body_cnt + 1'b1;
          if (int'(body_cnt) >= int'(decl_len) + 2) begin
            r.status        = StDone;
            r.packet_length = body_cnt + 9'd2;
            done            = 1'b1;
          end else begin
            r.status = StBusy;
          end
        end
      endcase
      if (r.write_enable) r.write_data = it.data_byte;
    end
    // timer acts after the state machine; the completing byte costs nothing
    if (done) begin
      rearm();
    end else if (ticks_left == '0) begin
      r.status = StTimeout;
      rearm();
    end else begin
      ticks_left = ticks_left - 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned field_bad(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    item_t   it;
    if (!rst_ni) begin
      timeout_ticks = ResetTimeout;
      decl_len      = '0;
      rearm();
      report_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status        = status_e'(m_axis_tuser_i[1:0]);
        got.write_enable  = m_axis_tuser_i[2];
        got.write_address = m_axis_tdata_i[8:0];
        got.write_data    = m_axis_tdata_i[16:9];
        got.packet_length = m_axis_tdata_i[25:17];
        if (report_q.size() == 0) begin
          $error("report with no item waiting: status %0d, address %0d",
                 got.status, got.write_address);
          err_count_o += 1;
        end else begin
          want = report_q.pop_front();
          err_count_o += field_bad("status", want.status, got.status);
          err_count_o += field_bad("write_enable", want.write_enable, got.write_enable);
          err_count_o += field_bad("write_address", want.write_address, got.write_address);
          err_count_o += field_bad("write_data", want.write_data, got.write_data);
          err_count_o += field_bad("packet_length", want.packet_length, got.packet_length);
          err_count_o += field_bad("tdata pad", 0, m_axis_tdata_i[31:26]);
        end
      end
      if (cfg_we_i) begin
        timeout_ticks = cfg_wdata_i;
        ticks_left    = {1'b0, cfg_wdata_i};
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        it.opcode    = op_e'(s_axis_tuser_i);
        it.data_byte = s_axis_tdata_i;
        report_q.push_back(deframe_step(it));
      end
      pending_o <= report_q.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the packet receiver testbench: clock, reset, stimulus and verdict.
module testbench;
  import slpr_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic [7:0]  s_data    = '0;
  logic        s_user    = 1'b0;
  logic        m_ready   = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_data;
  logic [2:0]  m_user;

  int unsigned err_count;
  int unsigned pending;
  int unsigned burst_left  = 0;
  int unsigned phase_items = 0;
  int unsigned rx_mode     = 0;
  int unsigned rx_left     = 0;
  int unsigned rx_hold     = 0;
  logic [15:0] phase_timeouts [9];

  sync_length_packet_receiver dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  slpr_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .err_count_o     (err_count),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver back-pressure: a new mode is drawn whenever the current run ends
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= ($urandom_range(0, 1) == 1);
      2: m_ready <= ($urandom_range(0, 7) != 0);
      default: begin
        if (rx_hold == 0) rx_hold = $urandom_range(1, 15);
        rx_hold--;
        m_ready <= (rx_hold == 0);
      end
    endcase
  end

  // one item; valid stays high inside a burst
  task automatic send_item(input op_e op, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= b;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    burst_left--;
    if (op == OpByte) phase_items++;
  endtask

  // occasional idle tick ahead of a byte; its data field is junk
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) send_item(OpTick, 8'($urandom_range(0, 255)));
    send_item(OpByte, b);
  endtask

  task automatic send_frame(input int unsigned len);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(8'(len));
    repeat (len + 2) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_packet();
    int unsigned kind;
    int unsigned pick;
    int unsigned len;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 49);
    if (pick < 3) len = $urandom_range(9, 40);
    else len = $urandom_range(0, 8);
    if (kind < 70) begin
      send_frame(len);
    end else if (kind < 80) begin
      send_byte(SyncFirst);
      send_byte(8'($urandom_range(1, 255)));
    end else if (kind < 90) begin
      // cut short: the next frame lands in this body
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      send_byte(8'(len));
      repeat ($urandom_range(0, len)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6))
        send_item(op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timeout(input logic [15:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    phase_timeouts = '{16'hFFFF, 16'd1, 16'd20, 16'd300, 16'd0, 16'd50, 16'd1000, 16'd7,
                       16'd0};
    phase_timeouts[8] = 16'($urandom_range(0, 65535));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset allowance: ticks, hunting noise, good frames, bad sync pairs
    send_item(OpTick, 8'h00);
    send_item(OpTick, 8'hFF);
    send_item(OpByte, 8'h7E);
    send_item(OpByte, SyncFirst);
    send_item(OpByte, SyncSecond);
    send_item(OpByte, 8'h00);
    send_item(OpByte, 8'h5A);
    send_item(OpByte, 8'hA5);
    send_item(OpByte, SyncFirst);
    send_item(OpByte, 8'h01);
    send_item(OpByte, SyncFirst);
    send_item(OpByte, SyncFirst);
    send_item(OpByte, SyncFirst);
    send_item(OpByte, SyncSecond);
    send_item(OpByte, 8'h02);
    send_item(OpByte, 8'h11);
    send_item(OpTick, 8'h00);
    send_item(OpByte, 8'h22);
    send_item(OpByte, 8'h33);
    send_item(OpByte, 8'h44);

    // zero allowance: every step times out, a taken byte is still written
    load_timeout(16'd0);
    send_item(OpTick, 8'h00);
    send_item(OpByte, SyncFirst);

    // allowance runs out on the length byte
    load_timeout(16'd2);
    send_item(OpByte, SyncFirst);
    send_item(OpByte, SyncSecond);
    send_item(OpByte, 8'h01);

    foreach (phase_timeouts[i]) begin
      load_timeout(phase_timeouts[i]);
      phase_items = 0;
      if (phase_timeouts[i] == 16'hFFFF) send_frame(255);
      while (phase_items < 12) send_packet();
    end

    drain();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
